[rtl/aes128_block_encrypt_top_assert.svh]
// Assertion macros for the AES-128 encrypt pipeline.
// Used by aes128_block_encrypt_top only.
`ifndef AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
// implication checked on every rising clock edge, disabled during reset
`define AES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/aes_pkg.sv]
// Package for the AES-128 encrypt pipeline: S-box, GF helpers, key step.
// No dependencies.
`default_nettype none
package aes_pkg;
  localparam int unsigned Rounds = 10;
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] RCON [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,
                                       8'h20,8'h40,8'h80,8'h1b,8'h36};

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 is bits 127:120; column c holds bytes 4c..4c+3
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int unsigned i);
    byte_at = s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = SBOX[byte_at(s, 4*((c+r)%4)+r)];
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c);   a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2); a3 = byte_at(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  // one step of the key schedule: round key r-1 to round key r
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction
endpackage
`default_nettype wire

[rtl/aes128_block_encrypt_top.sv]
// AES-128 ECB encrypt: ten-stage round pipeline with on-the-fly key schedule.
// Depends on aes_pkg and aes128_block_encrypt_top_assert.svh.
`default_nettype none
// Usage
//   Input: a block beat is taken at a clock edge where start_i is high and
//   busy_o is low. busy_o stays low, so a new block enters every cycle.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 key_high, 1 key_low)
//   and cfg_data_i; other indexes are ignored. cfg_ready_o is always high.
//   Change the key only while no block is in flight.
//   Output: done_o pulses for one cycle with cipher_high_o/cipher_low_o.
//   Pipeline: one stage per round plus the input AddRoundKey stage between
//   an accepted start and done_o. Throughput: one block per cycle, set
//   by the fully unrolled round stages; each stage also carries its round key.
//   Reset: clears valid bits and key registers to zero; no flush pass.
//   The receiver cannot stall; every result shows for exactly one cycle.
module aes128_block_encrypt_top import aes_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] plain_high_i,
  input  wire logic [63:0] plain_low_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             done_o,
  output logic [63:0]      cipher_high_o,
  output logic [63:0]      cipher_low_o
);
  logic [63:0] key_hi_q, key_lo_q;
  logic [Rounds:0]  vld_q;
  logic [127:0] st_q [Rounds+1];
  logic [127:0] rk_q [Rounds+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegKeyHigh) key_hi_q <= cfg_data_i;
      if (cfg_index_i == RegKeyLow)  key_lo_q <= cfg_data_i;
    end
  end

  // valid bits march with the blocks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[Rounds-1:0], start_i & ~busy_o};
  end

  // stage 0: initial AddRoundKey; stage r: round r, key expanded alongside
  always_ff @(posedge clk_i) begin
    st_q[0] <= {plain_high_i, plain_low_i} ^ {key_hi_q, key_lo_q};
    rk_q[0] <= {key_hi_q, key_lo_q};
    for (int r = 1; r <= Rounds; r++) begin
      rk_q[r] <= next_key(rk_q[r-1], RCON[r-1]);
      if (r == Rounds)
        st_q[r] <= sub_shift(st_q[r-1]) ^ next_key(rk_q[r-1], RCON[r-1]);
      else
        st_q[r] <= mix_cols(sub_shift(st_q[r-1])) ^ next_key(rk_q[r-1], RCON[r-1]);
    end
  end

  assign done_o        = vld_q[Rounds];
  assign cipher_high_o = st_q[Rounds][127:64];
  assign cipher_low_o  = st_q[Rounds][63:0];

`include "aes128_block_encrypt_top_assert.svh"
  // a taken block must later show up on done_o
  `AES_ASSERT_IMP(a_latency, start_i && !busy_o, ##11 done_o, "result missing after latency")
  // no result without an earlier taken block
  `AES_ASSERT_IMP(a_no_ghost, done_o, $past(start_i, 11), "result without input beat")
  // key schedule stage 1 tracks the stage-0 key
  `AES_ASSERT_NXT(a_key_step, 1'b1, rk_q[1] == next_key($past(rk_q[0]), RCON[0]),
    "key schedule stage mismatch")
endmodule
`default_nettype wire

[tb/aes128_block_encrypt_checker.sv]
// Scoreboard for the AES-128 encrypt block: watches key writes and block beats,
// predicts each ciphertext with its own cipher model and compares. Uses aes_pkg constants.
module aes128_block_encrypt_checker import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        done_o,
  input  logic [63:0] cipher_high_o,
  input  logic [63:0] cipher_low_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SubTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] cipher_q[$];

  function automatic logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // state bytes as an array, index 0 = most significant byte
  function automatic logic [127:0] encrypt_block(logic [127:0] key, logic [127:0] plain);
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [7:0]  rk [16];
    logic [7:0]  a0, a1, a2, a3, all, rc;
    logic [31:0] w [4];
    logic [31:0] t;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 0; i < 16; i++) st[i] = plain[127-8*i -: 8] ^ key[127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      t = {SubTab[w[3][23:16]] ^ rc, SubTab[w[3][15:8]], SubTab[w[3][7:0]],
           SubTab[w[3][31:24]]};
      w[0] ^= t; w[1] ^= w[0]; w[2] ^= w[1]; w[3] ^= w[2];
      rc = gmul2(rc);
      for (int i = 0; i < 16; i++) rk[i] = w[i/4][31-8*(i%4) -: 8];
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) tmp[4*c+k] = SubTab[st[4*((c+k)%4)+k]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
          tmp[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
          tmp[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
          tmp[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  assign pending_o = cipher_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      fail_count_o <= 0;
      cipher_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegKeyHigh) key_hi_q <= cfg_data_i;
        else if (cfg_index_i == RegKeyLow) key_lo_q <= cfg_data_i;
      end
      if (start_i && !busy_o)
        cipher_q.push_back(encrypt_block({key_hi_q, key_lo_q}, {plain_high_i, plain_low_i}));
      if (done_o) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected ciphertext beat %h_%h", $time, cipher_high_o, cipher_low_o);
          errs++;
        end else begin
          want = cipher_q.pop_front();
          if (cipher_high_o !== want[127:64]) begin
            $display("%0t: cipher_high expected %h actual %h", $time, want[127:64],
                     cipher_high_o);
            errs++;
          end
          if (cipher_low_o !== want[63:0]) begin
            $display("%0t: cipher_low expected %h actual %h", $time, want[63:0], cipher_low_o);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

[tb/testbench.sv]
// Top of the AES-128 encrypt testbench: clock, reset, key and block stimulus, verdict.
// Depends on aes_pkg, aes128_block_encrypt_top and aes128_block_encrypt_checker.
module testbench import aes_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 11;
  localparam int CycleCap  = 200000;

  logic        clk_i, rst_ni;
  logic        start_i, busy_o;
  logic [63:0] plain_high_i, plain_low_i;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        done_o;
  logic [63:0] cipher_high_o, cipher_low_o;
  int          fail_count, pending;
  int          cycle_cnt;

  aes128_block_encrypt_top DUT (.*);
  aes128_block_encrypt_checker u_chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: a hung pipeline must not run forever
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleCap) begin
        $display("aes128_block_encrypt_top test failed");
        $finish;
      end
    end
  end

  // random 64-bit word with a bias toward all-zero / all-one halves
  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v[63:32] = '0;
      3: v[31:0] = '1;
      default: ;
    endcase
    return v;
  endfunction

  // one key register write beat; only legal with nothing in flight
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one block beat, after a random idle gap when gaps is set; zero gap keeps start high back to back
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit gaps);
    int idle;
    idle = gaps ? $urandom_range(0, 14) : 0;
    if (idle > 0) begin
      start_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    plain_high_i <= hi;
    plain_low_i  <= lo;
    do @(posedge clk_i); while (busy_o);
  endtask

  // drain the pipeline before touching the key
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    start_i = 1'b0; plain_high_i = '0; plain_low_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset key (all zero), edge plaintexts
    send_block('0, '0, 0);
    send_block('1, '1, 0);
    send_block(64'h8000_0000_0000_0000, 64'h1, 0);
    drain();
    // standard FIPS-197 vector key
    write_reg(RegKeyHigh, 64'h0001_0203_0405_0607);
    write_reg(RegKeyLow,  64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 0);
    send_block('0, '1, 1);
    drain();
    // out-of-range index must be ignored
    write_reg(2'd2, '1);
    write_reg(2'd3, 64'hdead_beef_0bad_f00d);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 0);
    drain();
    // all-ones key
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    send_block('0, '0, 0);
    send_block('1, '1, 0);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1);
    drain();

    // random phases: new key per phase, blocks with mixed burst and idle stretches
    for (int ph = 0; ph < 18; ph++) begin
      bit bursty;
      write_reg(RegKeyHigh, rand_word());
      write_reg(RegKeyLow, rand_word());
      if (ph % 6 == 5) write_reg(2'($urandom_range(2, 3)), rand_word());
      bursty = (ph % 3 == 0);
      for (int n = 0; n < 50; n++) send_block(rand_word(), rand_word(), !bursty);
      drain();
    end
    // back to the reset-value key at the end
    write_reg(RegKeyHigh, '0);
    write_reg(RegKeyLow, '0);
    for (int n = 0; n < 10; n++) send_block(rand_word(), rand_word(), 1);
    drain();

    repeat (Latency + 4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("aes128_block_encrypt_top test passed");
    else
      $display("aes128_block_encrypt_top test failed");
    $finish;
  end
endmodule
